// File: design/rhsv_pkg.sv
// Package for the RGB to HSV converter: field widths, divider sizes,
// hue sector codes and hue base offsets.
// No dependencies.
package rhsv_pkg;

  // Field widths.
  localparam int COMP_W = 8;
  localparam int HUE_W  = 11;
  localparam int SAT_W  = 8;

  // Fraction bits of the hue within one sector.
  localparam int FRAC_W = 8;

  // Both divisions share one shape: a numerator of component width plus
  // fraction bits over a component-wide divisor, with a quotient of at
  // most FRAC_W + 1 bits.
  localparam int DIV_NUM_W = COMP_W + FRAC_W;
  localparam int DIV_DEN_W = COMP_W;
  localparam int DIV_Q_W   = FRAC_W + 1;

  // Register stages through the divider: entry, one per remaining step,
  // and the result register.
  localparam int DIV_LAT = DIV_Q_W + 1;

  // Hue codes.
  localparam logic [HUE_W-1:0] HUE_FULL       = 11'd1536;
  localparam logic [HUE_W-1:0] HUE_BASE_RED   = 11'd0;
  localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 11'd512;
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 11'd1024;

  // Which component is the largest, with red winning ties over green and
  // green over blue.
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

endpackage

// File: design/rhsv_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing but its parameters; the caller guarantees
// num < den * 2**Q_W so the quotient fits Q_W bits.
module rhsv_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 8,
  parameter int Q_W   = 9
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quot,
  output logic [DEN_W-1:0] rem
);

  // State entering each step.
  logic [DEN_W-1:0] r_rem [Q_W];
  logic [Q_W-1:0]   r_low [Q_W];
  logic [Q_W-1:0]   r_q   [Q_W];
  logic [DEN_W-1:0] r_den [Q_W];

  // Result of each step.
  logic [DEN_W-1:0] rem_next [Q_W];
  logic [Q_W-1:0]   low_next [Q_W];
  logic [Q_W-1:0]   q_next   [Q_W];

  // One compare and subtract per step: shift in the next numerator bit.
  always_comb begin
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;
    for (int k = 0; k < Q_W; k++) begin
      trial       = {r_rem[k], r_low[k][Q_W-1]};
      diff        = trial - {1'b0, r_den[k]};
      fits        = (trial >= {1'b0, r_den[k]});
      rem_next[k] = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_next[k] = r_low[k] << 1;
      q_next[k]   = {r_q[k][Q_W-2:0], fits};
    end
  end

  // Entry stage takes the top numerator bits as the first remainder.
  always_ff @(posedge clk) begin
    r_rem[0] <= DEN_W'(num[NUM_W-1:Q_W]);
    r_low[0] <= num[Q_W-1:0];
    r_q[0]   <= '0;
    r_den[0] <= den;
    for (int k = 1; k < Q_W; k++) begin
      r_rem[k] <= rem_next[k-1];
      r_low[k] <= low_next[k-1];
      r_q[k]   <= q_next[k-1];
      r_den[k] <= r_den[k-1];
    end
    quot <= q_next[Q_W-1];
    rem  <= rem_next[Q_W-1];
  end

endmodule

// File: design/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front-end stages, two divider
// pipelines and the hue assembly stage.
// Depends on rhsv_pkg and rhsv_div.
//
//   Channel  Handshake       Fields                                   Direction
//   input    start / busy    red, green, blue                         in
//   result   done (strobe)   hue_code, saturation, brightness_value   out
//
// A pixel is taken in every cycle in which start is high; busy stays low.
// Each result appears for one cycle with done.
// The latency is set by the divider pipelines, one quotient bit per stage.
// Reset clears only the valid bits; results cannot be held off downstream.
module rgb_to_hsv_converter
  import rhsv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [COMP_W-1:0] red,
  input  logic [COMP_W-1:0] green,
  input  logic [COMP_W-1:0] blue,
  output logic              done,
  output logic [HUE_W-1:0]  hue_code,
  output logic [SAT_W-1:0]  saturation,
  output logic [COMP_W-1:0] brightness_value
);

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Stage 1: register the pixel.
  logic              s1_valid;
  logic [COMP_W-1:0] s1_red, s1_green, s1_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_red   <= red;
    s1_green <= green;
    s1_blue  <= blue;
  end

  // Largest and smallest component, sector and the hue difference operands.
  logic [COMP_W-1:0] s1_max, s1_min, s1_opa, s1_opb;
  sector_t           s1_sec;

  always_comb begin
    s1_min = s1_red;
    if (s1_green < s1_min) s1_min = s1_green;
    if (s1_blue < s1_min) s1_min = s1_blue;
    priority if (s1_red >= s1_green && s1_red >= s1_blue) begin
      s1_max = s1_red;
      s1_sec = SEC_RED;
      s1_opa = s1_green;
      s1_opb = s1_blue;
    end else if (s1_green >= s1_blue) begin
      s1_max = s1_green;
      s1_sec = SEC_GREEN;
      s1_opa = s1_blue;
      s1_opb = s1_red;
    end else begin
      s1_max = s1_blue;
      s1_sec = SEC_BLUE;
      s1_opa = s1_red;
      s1_opb = s1_green;
    end
  end

  // Stage 2.
  logic              s2_valid;
  logic [COMP_W-1:0] s2_max, s2_min, s2_opa, s2_opb;
  sector_t           s2_sec;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_max <= s1_max;
    s2_min <= s1_min;
    s2_opa <= s1_opa;
    s2_opb <= s1_opb;
    s2_sec <= s1_sec;
  end

  // Spread, magnitude and sign of the hue difference, and both numerators.
  logic [COMP_W-1:0]    s2_spread, s2_absdiff;
  logic                 s2_neg;
  logic [DIV_NUM_W-1:0] s2_num_sat, s2_num_hue;

  always_comb begin
    s2_spread  = s2_max - s2_min;
    s2_neg     = (s2_opa < s2_opb);
    s2_absdiff = s2_neg ? (s2_opb - s2_opa) : (s2_opa - s2_opb);
    // Full-scale times spread, as (spread << FRAC_W) - spread.
    s2_num_sat = {s2_spread, {FRAC_W{1'b0}}} - DIV_NUM_W'(s2_spread);
    s2_num_hue = {s2_absdiff, {FRAC_W{1'b0}}};
  end

  // Stage 3: divider inputs and the side information.
  logic                 s3_valid;
  logic [COMP_W-1:0]    s3_max, s3_spread;
  logic                 s3_neg;
  sector_t              s3_sec;
  logic [DIV_NUM_W-1:0] s3_num_sat, s3_num_hue;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_max     <= s2_max;
    s3_spread  <= s2_spread;
    s3_neg     <= s2_neg;
    s3_sec     <= s2_sec;
    s3_num_sat <= s2_num_sat;
    s3_num_hue <= s2_num_hue;
  end

  // Saturation quotient: full-scale * spread / max.
  logic [DIV_Q_W-1:0]   sat_quot;
  logic [DIV_DEN_W-1:0] sat_rem;

  rhsv_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_div_sat (
    .clk  (clk),
    .num  (s3_num_sat),
    .den  (s3_max),
    .quot (sat_quot),
    .rem  (sat_rem)
  );

  // Hue fraction: 256 * |difference| / spread.
  logic [DIV_Q_W-1:0]   hue_quot;
  logic [DIV_DEN_W-1:0] hue_rem;

  rhsv_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_div_hue (
    .clk  (clk),
    .num  (s3_num_hue),
    .den  (s3_spread),
    .quot (hue_quot),
    .rem  (hue_rem)
  );

  // Side information delayed to line up with the divider results.
  logic              dl_valid [DIV_LAT];
  logic [COMP_W-1:0] dl_max   [DIV_LAT];
  logic              dl_neg   [DIV_LAT];
  logic              dl_gray  [DIV_LAT];
  sector_t           dl_sec   [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        dl_valid[k] <= 1'b0;
      end
    end else begin
      dl_valid[0] <= s3_valid;
      for (int k = 1; k < DIV_LAT; k++) begin
        dl_valid[k] <= dl_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_max[0]  <= s3_max;
    dl_neg[0]  <= s3_neg;
    dl_gray[0] <= (s3_spread == '0);
    dl_sec[0]  <= s3_sec;
    for (int k = 1; k < DIV_LAT; k++) begin
      dl_max[k]  <= dl_max[k-1];
      dl_neg[k]  <= dl_neg[k-1];
      dl_gray[k] <= dl_gray[k-1];
      dl_sec[k]  <= dl_sec[k-1];
    end
  end

  // Hue assembly: sector base plus or minus the floored fraction, or zero for a
  // gray pixel. A negative fraction in the red sector wraps around from the full circle.
  logic [HUE_W-1:0] hue_base, hue_off, hue_next;
  logic [SAT_W-1:0] sat_next;
  logic             hue_round;

  always_comb begin
    hue_round = (hue_rem != '0);
    hue_off   = HUE_W'(hue_quot) + HUE_W'(hue_round);
    unique case (dl_sec[DIV_LAT-1])
      SEC_RED:   hue_base = dl_neg[DIV_LAT-1] ? HUE_FULL : HUE_BASE_RED;
      SEC_GREEN: hue_base = HUE_BASE_GREEN;
      SEC_BLUE:  hue_base = HUE_BASE_BLUE;
      default:   hue_base = HUE_BASE_RED;
    endcase
    if (dl_gray[DIV_LAT-1]) begin
      hue_next = '0;
    end else if (dl_neg[DIV_LAT-1]) begin
      hue_next = hue_base - hue_off;
    end else begin
      hue_next = hue_base + HUE_W'(hue_quot);
    end
    // A black pixel has zero saturation.
    sat_next = (dl_max[DIV_LAT-1] == '0) ? '0 : sat_quot[SAT_W-1:0];
  end

  // Output registers: each result transfer lasts one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dl_valid[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    hue_code         <= hue_next;
    saturation       <= sat_next;
    brightness_value <= dl_max[DIV_LAT-1];
  end

endmodule

// File: dv/tb_rgb_to_hsv_converter.sv
// Self-checking testbench for rgb_to_hsv_converter: directed and random pixels,
// with an HSV predictor and an in-order scoreboard held in a small class.
// Depends on rhsv_pkg and the converter RTL.
module tb_rgb_to_hsv_converter
  import rhsv_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_REPORTS  = 10;

  // One expected HSV result together with the pixel that produced it.
  typedef struct {
    logic [COMP_W-1:0] r, g, b;
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  sat;
    logic [COMP_W-1:0] val;
  } hsv_expect_t;

  // Scoreboard: predicts HSV for each transfer in and checks results in order.
  class hsv_scoreboard;
    hsv_expect_t pending_hsv[$];
    int errors;

    function hsv_expect_t predict_hsv(logic [COMP_W-1:0] r, g, b);
      int ri, gi, bi, mx, mn, d, diff, num, hue, base_code;
      int maxc;
      sector_t sec;
      hsv_expect_t res;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      maxc = (1 << COMP_W) - 1;
      mx = ri;
      mn = ri;
      if (gi > mx) mx = gi;
      if (bi > mx) mx = bi;
      if (gi < mn) mn = gi;
      if (bi < mn) mn = bi;
      d = mx - mn;
      // Red wins ties over green, green over blue.
      if (mx == ri) sec = SEC_RED;
      else if (mx == gi) sec = SEC_GREEN;
      else sec = SEC_BLUE;
      case (sec)
        SEC_RED: begin
          base_code = int'(HUE_BASE_RED);
          diff = gi - bi;
        end
        SEC_GREEN: begin
          base_code = int'(HUE_BASE_GREEN);
          diff = bi - ri;
        end
        default: begin
          base_code = int'(HUE_BASE_BLUE);
          diff = ri - gi;
        end
      endcase
      hue = 0;
      if (d > 0) begin
        // Floor division of the scaled difference, then wrap negatives.
        num = diff * (1 << FRAC_W);
        if (num >= 0) hue = base_code + num / d;
        else hue = base_code - ((-num + d - 1) / d);
        if (hue < 0) hue += int'(HUE_FULL);
      end
      res.r = r;
      res.g = g;
      res.b = b;
      res.hue = hue[HUE_W-1:0];
      res.sat = (mx > 0) ? SAT_W'((maxc * d) / mx) : '0;
      res.val = mx[COMP_W-1:0];
      return res;
    endfunction

    function void note_pixel(logic [COMP_W-1:0] r, g, b);
      pending_hsv.push_back(predict_hsv(r, g, b));
    endfunction

    function void check_result(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                               logic [COMP_W-1:0] val);
      hsv_expect_t exp_hsv;
      if (pending_hsv.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("Unexpected result: hue %0d sat %0d val %0d", hue, sat, val);
        return;
      end
      exp_hsv = pending_hsv.pop_front();
      if (hue !== exp_hsv.hue || sat !== exp_hsv.sat || val !== exp_hsv.val) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $write("Mismatch for rgb %0d %0d %0d: expected hue %0d sat %0d val %0d, ",
                 exp_hsv.r, exp_hsv.g, exp_hsv.b, exp_hsv.hue, exp_hsv.sat,
                 exp_hsv.val);
          $display("got hue %0d sat %0d val %0d", hue, sat, val);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [COMP_W-1:0] red, green, blue;
  logic              done;
  logic [HUE_W-1:0]  hue_code;
  logic [SAT_W-1:0]  saturation;
  logic [COMP_W-1:0] brightness_value;

  hsv_scoreboard hsv_sb = new();
  int pixels_taken = 0;
  int cycle_count = 0;

  rgb_to_hsv_converter uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .done             (done),
    .hue_code         (hue_code),
    .saturation       (saturation),
    .brightness_value (brightness_value)
  );

  always #CLK_HALF clk = ~clk;

  // Monitor: notes each input transfer and checks each result strobe.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        hsv_sb.note_pixel(red, green, blue);
        pixels_taken++;
      end
      if (done) hsv_sb.check_result(hue_code, saturation, brightness_value);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pixel(input logic [COMP_W-1:0] r, g, b, input int idle_pct);
    int taken_before;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      red   <= COMP_W'($urandom);
      green <= COMP_W'($urandom);
      blue  <= COMP_W'($urandom);
      @(negedge clk);
    end
    taken_before = pixels_taken;
    start <= 1'b1;
    red   <= r;
    green <= g;
    blue  <= b;
    do @(negedge clk); while (pixels_taken == taken_before);
  endtask

  // Random pixel drawn from one of several shapes that stress the hue logic.
  task automatic send_random_pixel(input int idle_pct);
    logic [COMP_W-1:0] c[3];
    int mid, k;
    case ($urandom_range(4))
      0: begin
        // Nearly gray: small spread, so d is tiny.
        mid = $urandom_range(255);
        for (k = 0; k < 3; k++)
          c[k] = COMP_W'(mid + $urandom_range(6) - 3);
      end
      1: begin
        // Two components tie, often for the largest.
        c[0] = COMP_W'($urandom);
        c[1] = c[0];
        c[2] = COMP_W'($urandom);
        k = $urandom_range(2);
        c[k] = c[(k + 1) % 3];
        c[(k + 2) % 3] = COMP_W'($urandom);
      end
      2: begin
        // Components mostly at the ends of the range, some random.
        for (k = 0; k < 3; k++)
          c[k] = ($urandom_range(2) == 0) ? COMP_W'($urandom)
                 : ($urandom_range(1) ? '1 : '0);
      end
      default: begin
        for (k = 0; k < 3; k++) c[k] = COMP_W'($urandom);
      end
    endcase
    send_pixel(c[0], c[1], c[2], idle_pct);
  endtask

  initial begin
    int i, idle_pct, wait_cycles;
    rst   = 1'b1;
    start = 1'b0;
    red   = '0;
    green = '0;
    blue  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pixels: black, white, gray, primaries, ties and hue wrap.
    send_pixel(8'd0,   8'd0,   8'd0,   28);
    send_pixel(8'd255, 8'd255, 8'd255, 28);
    send_pixel(8'd128, 8'd128, 8'd128, 28);
    send_pixel(8'd1,   8'd1,   8'd1,   28);
    send_pixel(8'd255, 8'd0,   8'd0,   28);
    send_pixel(8'd0,   8'd255, 8'd0,   28);
    send_pixel(8'd0,   8'd0,   8'd255, 28);
    send_pixel(8'd255, 8'd255, 8'd0,   28);
    send_pixel(8'd0,   8'd255, 8'd255, 28);
    send_pixel(8'd255, 8'd0,   8'd255, 28);
    send_pixel(8'd255, 8'd0,   8'd1,   28);
    send_pixel(8'd200, 8'd10,  8'd199, 28);
    send_pixel(8'd1,   8'd0,   8'd0,   28);
    send_pixel(8'd0,   8'd1,   8'd0,   28);
    send_pixel(8'd0,   8'd0,   8'd1,   28);
    send_pixel(8'd255, 8'd254, 8'd0,   28);
    send_pixel(8'd0,   8'd255, 8'd254, 28);
    send_pixel(8'd254, 8'd0,   8'd255, 28);
    send_pixel(8'd1,   8'd0,   8'd255, 28);
    send_pixel(8'd255, 8'd255, 8'd254, 28);

    // Random pixels in three idling phases: light, heavy, none.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < RANDOM_ITEMS / 3) idle_pct = 28;
      else if (i < 2 * RANDOM_ITEMS / 3) idle_pct = 71;
      else idle_pct = 0;
      send_random_pixel(idle_pct);
    end
    start <= 1'b0;

    // Drain outstanding results, then watch for stray strobes.
    wait_cycles = 0;
    while (hsv_sb.pending_hsv.size() != 0 && wait_cycles < 1000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    hsv_sb.errors += hsv_sb.pending_hsv.size();

    if (hsv_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
